// ===== src/tea_block_cipher_unit_assert.svh =====
// ----------------------------------------------------------------------------
// TEA block cipher unit assertion macros
// Concurrent checks clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TEA_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define TEA_BLOCK_CIPHER_UNIT_ASSERT_SVH

// antecedent implies consequent on the next clock edge
`define TEA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// antecedent implies consequent on the same clock edge
`define TEA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== src/tea_pkg.sv =====
// ----------------------------------------------------------------------------
// TEA package
// Beat types, pipeline stage type, key type and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tea_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEY_WORD0 = 2'd0,
		REG_KEY_WORD1 = 2'd1,
		REG_KEY_WORD2 = 2'd2,
		REG_KEY_WORD3 = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} opcode_t;

	typedef struct packed {
		logic              opcode;
		logic [WORD_W-1:0] block_first;
		logic [WORD_W-1:0] block_second;
	} in_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_first;
		logic [WORD_W-1:0] result_second;
	} out_beat_t;

	typedef struct packed {
		logic              opcode;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
	} stage_t;

	typedef struct packed {
		logic [WORD_W-1:0] key_word0;
		logic [WORD_W-1:0] key_word1;
		logic [WORD_W-1:0] key_word2;
		logic [WORD_W-1:0] key_word3;
	} key_t;

endpackage

`default_nettype wire

// ===== src/tea_key_regs.sv =====
// ----------------------------------------------------------------------------
// TEA key registers
// Four 32-bit key words written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_key_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tea_pkg::WORD_W-1:0]    cfg_data,
	output tea_pkg::key_t                      key
);
	import tea_pkg::*;

	key_t key_q;

	assign cfg_ready = 1'b1;
	assign key       = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_WORD0: key_q.key_word0 <= cfg_data;
				REG_KEY_WORD1: key_q.key_word1 <= cfg_data;
				REG_KEY_WORD2: key_q.key_word2 <= cfg_data;
				REG_KEY_WORD3: key_q.key_word3 <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/tea_half_round.sv =====
// ----------------------------------------------------------------------------
// TEA half-round stage
// One Feistel half-round for encryption or decryption, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_half_round #(
	parameter int unsigned STAGE  = 0,
	parameter int unsigned ROUNDS = 32,
	parameter logic [31:0] DELTA  = 32'h9E3779B9
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           valid_in,
	input  tea_pkg::stage_t     data_in,
	input  tea_pkg::key_t       key,
	output logic                valid_out,
	output tea_pkg::stage_t     data_out
);
	import tea_pkg::*;

	localparam int unsigned ROUND   = STAGE / 2;
	localparam logic        EVEN    = ((STAGE % 2) == 0);
	localparam logic [63:0] SUM_ENC_W = 64'(DELTA) * 64'(ROUND + 1);
	localparam logic [63:0] SUM_DEC_W = 64'(DELTA) * 64'(ROUNDS - ROUND);
	localparam logic [WORD_W-1:0] SUM_ENC = SUM_ENC_W[WORD_W-1:0];
	localparam logic [WORD_W-1:0] SUM_DEC = SUM_DEC_W[WORD_W-1:0];

	logic              enc;
	logic              upd_first;
	logic [WORD_W-1:0] src;
	logic [WORD_W-1:0] dst;
	logic [WORD_W-1:0] ka;
	logic [WORD_W-1:0] kb;
	logic [WORD_W-1:0] sum;
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] dst_new;
	stage_t            next;

	logic   valid_s1;
	stage_t data_s1;

	always_comb begin
		enc       = (opcode_t'(data_in.opcode) == OP_ENCRYPT);
		// encryption updates x first in a round, decryption updates y first
		upd_first = enc ? EVEN : !EVEN;
		src       = upd_first ? data_in.y : data_in.x;
		dst       = upd_first ? data_in.x : data_in.y;
		ka        = upd_first ? key.key_word0 : key.key_word2;
		kb        = upd_first ? key.key_word1 : key.key_word3;
		sum       = enc ? SUM_ENC : SUM_DEC;
		mix       = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
		dst_new   = enc ? (dst + mix) : (dst - mix);
		next      = data_in;
		if (upd_first) begin
			next.x = dst_new;
		end else begin
			next.y = dst_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			data_s1 <= next;
		end
	end

	assign valid_out = valid_s1;
	assign data_out  = data_s1;

endmodule

`default_nettype wire

// ===== src/tea_block_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// TEA block cipher unit
// Pipelined 64-bit TEA encryption and decryption under a 128-bit key.
// ----------------------------------------------------------------------------
// Each block passes through 2*ROUNDS register stages, one Feistel half-round
// per stage, and a new block can be taken every cycle while the output beat
// is not stalled. The opcode travels with the block, so encrypt and decrypt
// beats mix freely. When the output beat is stalled the whole pipeline holds
// and the input is stalled. Key words are to be written by the user only
// while no block is in flight; the block itself does not enforce this.
`default_nettype none

`include "tea_block_cipher_unit_assert.svh"

module tea_block_cipher_unit #(
	parameter int unsigned ROUNDS = 32,
	parameter logic [31:0] DELTA  = 32'h9E3779B9
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  tea_pkg::in_beat_t                    in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output tea_pkg::out_beat_t                   out_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tea_pkg::WORD_W-1:0]      cfg_data
);
	import tea_pkg::*;

	localparam int unsigned STAGES = 2 * ROUNDS;

	key_t             key;
	logic             en;
	logic [STAGES:0]  stage_valid;
	stage_t           stage_data [STAGES+1];

	tea_key_regs u_key_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key)
	);

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	assign stage_valid[0]       = in_valid;
	assign stage_data[0].opcode = in_data.opcode;
	assign stage_data[0].x      = in_data.block_first;
	assign stage_data[0].y      = in_data.block_second;

	for (genvar h = 0; h < STAGES; h++) begin : g_stage
		tea_half_round #(
			.STAGE  (h),
			.ROUNDS (ROUNDS),
			.DELTA  (DELTA)
		) u_half_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (stage_valid[h]),
			.data_in   (stage_data[h]),
			.key       (key),
			.valid_out (stage_valid[h+1]),
			.data_out  (stage_data[h+1])
		);
	end

	assign out_valid              = stage_valid[STAGES];
	assign out_data.result_first  = stage_data[STAGES].x;
	assign out_data.result_second = stage_data[STAGES].y;

	`TEA_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, stage_valid[1],
		"accepted beat did not enter the first stage")
	`TEA_ASSERT_NEXT(a_stall_freezes, out_valid && out_stall, $stable(stage_valid[STAGES:1]),
		"pipeline moved while output stalled")
	`TEA_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
		"input stalled without a stalled output beat")

endmodule

`default_nettype wire

// ===== dv/tea_block_cipher_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TEA block cipher checker
// Watches the key write, block and result channels, computes the TEA result
// of every accepted block under the key in force and compares result beats
// in order, field by field.
// ----------------------------------------------------------------------------

module tea_block_cipher_checker #(
	parameter int unsigned ROUNDS = 32,
	parameter logic [31:0] DELTA  = 32'h9E3779B9
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  tea_pkg::in_beat_t                    in_data,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  tea_pkg::out_beat_t                   out_data,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tea_pkg::WORD_W-1:0]      cfg_data,
	output int                                   error_count,
	output int                                   blocks_in_flight
);
	import tea_pkg::*;

	key_t      cipher_key;
	out_beat_t expected_results[$];
	out_beat_t want;

	function automatic logic [31:0] feistel_mix(input logic [31:0] half,
			input logic [31:0] sum, input logic [31:0] ka, input logic [31:0] kb);
		return ((half << 4) + ka) ^ (half + sum) ^ ((half >> 5) + kb);
	endfunction

	function automatic out_beat_t tea_cipher_predict(input in_beat_t blk, input key_t k);
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] sum;
		out_beat_t   res;
		x = blk.block_first;
		y = blk.block_second;
		if (opcode_t'(blk.opcode) == OP_ENCRYPT) begin
			sum = '0;
			for (int r = 0; r < ROUNDS; r++) begin
				sum = sum + DELTA;
				x   = x + feistel_mix(y, sum, k.key_word0, k.key_word1);
				y   = y + feistel_mix(x, sum, k.key_word2, k.key_word3);
			end
		end else begin
			sum = 32'(DELTA * ROUNDS);
			for (int r = 0; r < ROUNDS; r++) begin
				y   = y - feistel_mix(x, sum, k.key_word2, k.key_word3);
				x   = x - feistel_mix(y, sum, k.key_word0, k.key_word1);
				sum = sum - DELTA;
			end
		end
		res.result_first  = x;
		res.result_second = y;
		return res;
	endfunction

	function automatic void flag_error(input string what);
		error_count++;
		if (error_count <= 10)
			$display("%0t: ERROR %s", $realtime, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_key = '0;
			expected_results.delete();
			error_count      = 0;
			blocks_in_flight = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(tea_cipher_predict(in_data, cipher_key));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					flag_error($sformatf("result beat with nothing pending: %h", out_data));
				end else begin
					want = expected_results.pop_front();
					if (out_data.result_first !== want.result_first)
						flag_error($sformatf("result_first expected %h got %h",
							want.result_first, out_data.result_first));
					if (out_data.result_second !== want.result_second)
						flag_error($sformatf("result_second expected %h got %h",
							want.result_second, out_data.result_second));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_KEY_WORD0: cipher_key.key_word0 = cfg_data;
					REG_KEY_WORD1: cipher_key.key_word1 = cfg_data;
					REG_KEY_WORD2: cipher_key.key_word2 = cfg_data;
					REG_KEY_WORD3: cipher_key.key_word3 = cfg_data;
					default: ;
				endcase
			end
			blocks_in_flight = expected_results.size();
		end
	end

endmodule

// ===== dv/tea_block_cipher_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TEA block cipher unit testbench
// Loads a series of keys (reset, all-zero, all-one, mixed and random),
// sends directed edge blocks and then random encrypt and decrypt beats with
// random gaps and output stalls, including one long output hold that backs
// the pipeline up. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tea_block_cipher_unit_tb;
	import tea_pkg::*;

	localparam int unsigned ROUNDS         = 32;
	localparam logic [31:0] DELTA          = 32'h9E3779B9;
	localparam int          PHASES         = 6;
	localparam int          BLOCKS_PER_PHASE = 115;
	localparam int          SQUEEZE_CYCLES = 300;
	localparam int          WATCHDOG_LIMIT = 3000;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	in_beat_t               in_data;
	logic                   out_valid;
	logic                   out_stall;
	out_beat_t              out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [WORD_W-1:0]      cfg_data;

	int error_count;
	int blocks_in_flight;
	int idle_cycles = 0;
	bit sender_burst = 1'b0;
	bit squeeze_req = 1'b0;
	bit squeeze_active = 1'b0;
	bit squeeze_done = 1'b0;

	tea_block_cipher_unit #(
		.ROUNDS(ROUNDS),
		.DELTA (DELTA)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	tea_block_cipher_checker #(
		.ROUNDS(ROUNDS),
		.DELTA (DELTA)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.error_count     (error_count),
		.blocks_in_flight(blocks_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'h1 << $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_block(input opcode_t op, input logic [31:0] a, input logic [31:0] b);
		int gap;
		gap = sender_burst ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{opcode: op, block_first: a, block_second: b};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_key(input key_t k);
		cfg_write(REG_KEY_WORD0, k.key_word0);
		cfg_write(REG_KEY_WORD1, k.key_word1);
		cfg_write(REG_KEY_WORD2, k.key_word2);
		cfg_write(REG_KEY_WORD3, k.key_word3);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (blocks_in_flight != 0) @(negedge clk);
	endtask

	// result side: random stalls, free-running stretches and one long hold
	initial begin
		int free_len;
		int hold_len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (squeeze_req && !squeeze_done) begin
				@(negedge clk) out_stall <= 1'b1;
				squeeze_active = 1'b1;
				repeat (SQUEEZE_CYCLES - 1) @(negedge clk);
				squeeze_done = 1'b1;
			end
			free_len = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 150)
				: $urandom_range(1, 6);
			hold_len = pick_gap();
			repeat (free_len) @(negedge clk) out_stall <= 1'b0;
			repeat (hold_len) @(negedge clk) out_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		key_t k;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset key (all zero)
		send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(OP_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
		send_block(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000);
		send_block(OP_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
		send_block(OP_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
		send_block(OP_DECRYPT, 32'h41EA_3A0A, 32'h94BA_A940);
		send_block(OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
		drain();

		load_key('{key_word0: '1, key_word1: '1, key_word2: '1, key_word3: '1});
		send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(OP_ENCRYPT, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: k = '{key_word0: '0, key_word1: '1, key_word2: '0, key_word3: '1};
				2: k = '{key_word0: '1, key_word1: '0, key_word2: '1, key_word3: '0};
				4: k = '{key_word0: 32'h0123_4567, key_word1: 32'h89AB_CDEF,
					key_word2: 32'hFEDC_BA98, key_word3: 32'h7654_3210};
				default: k = '{key_word0: $urandom(), key_word1: $urandom(),
					key_word2: $urandom(), key_word3: $urandom()};
			endcase
			load_key(k);
			sender_burst = (phase % 2 == 1);
			if (phase == 1) begin
				// start the burst only once the long output hold is on
				squeeze_req = 1'b1;
				wait (squeeze_active);
			end
			for (int n = 0; n < BLOCKS_PER_PHASE; n++)
				send_block(opcode_t'($urandom_range(0, 1)), pick_word(), pick_word());
			drain();
		end

		load_key('0);
		repeat (2 * ROUNDS + 16) @(negedge clk);
		if (error_count == 0 && blocks_in_flight == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
